@@ sv/wspd_pkg.sv @@
// Package for the wheel speed PD regulator: sizes, codes and defaults.
`default_nettype none
package wspd_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_WHEELS_DEF    = 2;
  localparam int FRACTION_BITS_DEF = 8;

  // Fixed arithmetic sizes
  localparam int POS_W       = 48;   // virtual position and error width
  localparam int GAIN_W      = 16;   // kp / kd width, Q4.12
  localparam int GAIN_FRAC   = 12;
  localparam int SPEED_W     = 16;   // set speed width, Q8.8
  localparam int SPEED_FRAC  = 8;
  localparam int COUNT_W     = 32;   // encoder and target count width
  localparam int PWR_W       = 8;    // integer power width
  localparam int POWER_LIMIT = 100;

  // Request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_RUN    = 2'd1;
  localparam logic [1:0] REQ_TARGET = 2'd2;

  // Run modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_RUN    = 2'd1;
  localparam logic [1:0] MODE_TARGET = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED1 = 2'd3;
  localparam int CFG_DATA_W = 16;

endpackage
`default_nettype wire

@@ sv/wheel_speed_pd_regulator.sv @@
// Top level of the wheel speed PD regulator: per-wheel state and PD datapath.
`default_nettype none
// Incremental PD speed regulator for NUM_WHEELS wheels. Each input beat is a
// control tick or a start request for one wheel and yields exactly one result
// beat. Throughput is one beat per clock unless out_ready stalls the result;
// a beat passes the input register, then the result register. The single-pass
// datapath reads and writes back per-wheel state in the same cycle, so a beat
// for the same wheel may follow directly; the result register lets a new beat
// enter while an earlier result waits. Configuration (kp, kd, wheel speeds) is
// written via cfg_wr_en; the user must write it while idle, the block does not enforce it.
module wheel_speed_pd_regulator #(
  parameter int NUM_WHEELS    = wspd_pkg::NUM_WHEELS_DEF,
  parameter int FRACTION_BITS = wspd_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [wspd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wspd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_req_type,
  input  wire logic                                in_wheel,
  input  wire logic signed [wspd_pkg::COUNT_W-1:0] in_encoder_count,
  input  wire logic signed [wspd_pkg::PWR_W-1:0]   in_start_power,
  input  wire logic signed [wspd_pkg::COUNT_W-1:0] in_target_count,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_wheel_out,
  output logic signed [wspd_pkg::PWR_W-1:0]        out_drive_power,
  output logic [1:0]                               out_mode_now,
  output logic                                     out_target_reached,
  output logic                                     out_power_clamped
);
  import wspd_pkg::*;

  localparam int WIDX    = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
  localparam int AW      = FRACTION_BITS + 8;          // accumulated power width
  localparam int SHL     = (FRACTION_BITS >= SPEED_FRAC) ? FRACTION_BITS - SPEED_FRAC : 0;
  localparam int SHR     = (FRACTION_BITS >= SPEED_FRAC) ? 0 : SPEED_FRAC - FRACTION_BITS;
  localparam int PROD_W  = POS_W + GAIN_W + 1;
  localparam int TERM_W  = PROD_W - GAIN_FRAC;
  localparam int DELTA_W = TERM_W + 1;
  localparam int NP_W    = DELTA_W + 1;
  localparam logic signed [NP_W-1:0] LIM     = NP_W'(POWER_LIMIT * (2 ** FRACTION_BITS));
  localparam logic signed [NP_W-1:0] NEG_LIM = -LIM;

  // Truncate a fixed-point power toward zero to its integer part
  function automatic logic signed [PWR_W-1:0] trunc_pwr(input logic signed [AW-1:0] p);
    logic [AW:0] ext;
    logic [AW:0] mag;
    logic [AW:0] q;
    ext = {p[AW-1], p};
    mag = p[AW-1] ? (~ext + 1'b1) : ext;
    q   = mag >> FRACTION_BITS;
    return p[AW-1] ? PWR_W'(~q + 1'b1) : PWR_W'(q);
  endfunction

  // Configuration registers
  logic [GAIN_W-1:0]         kp_r, kd_r;
  logic signed [SPEED_W-1:0] spd0_r, spd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      kd_r   <= '0;
      spd0_r <= '0;
      spd1_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KP:     kp_r   <= cfg_wdata;
        CFG_KD:     kd_r   <= cfg_wdata;
        CFG_SPEED0: spd0_r <= cfg_wdata;
        CFG_SPEED1: spd1_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  logic                      in_valid_r;
  logic [1:0]                req_r;
  logic                      wheel_r;
  logic signed [COUNT_W-1:0] enc_r;
  logic signed [PWR_W-1:0]   sp_r;
  logic signed [COUNT_W-1:0] tgt_cnt_r;
  logic                      fire;

  assign fire     = in_valid_r && (!out_valid || out_ready);
  assign in_ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r     <= in_req_type;
      wheel_r   <= in_wheel;
      enc_r     <= in_encoder_count;
      sp_r      <= in_start_power;
      tgt_cnt_r <= in_target_count;
    end
  end

  // Per-wheel state
  logic signed [POS_W-1:0]   vp_r   [NUM_WHEELS];
  logic signed [POS_W-1:0]   perr_r [NUM_WHEELS];
  logic signed [AW-1:0]      acc_r  [NUM_WHEELS];
  logic [1:0]                mode_r [NUM_WHEELS];
  logic signed [COUNT_W-1:0] tgt_r  [NUM_WHEELS];

  logic [WIDX-1:0] widx;
  logic            in_range;

  assign widx     = WIDX'(wheel_r);
  assign in_range = (32'(wheel_r) < 32'(NUM_WHEELS));

  logic signed [POS_W-1:0]   vp_cur, perr_cur;
  logic signed [AW-1:0]      acc_cur;
  logic [1:0]                mode_cur;
  logic signed [COUNT_W-1:0] tgt_cur;

  assign vp_cur   = vp_r[widx];
  assign perr_cur = perr_r[widx];
  assign acc_cur  = acc_r[widx];
  assign mode_cur = mode_r[widx];
  assign tgt_cur  = tgt_r[widx];

  // PD datapath: advance position, error, derivative, gain products
  logic signed [SPEED_W-1:0] spd_sel;
  logic signed [POS_W-1:0]   spd_ext, spd_al, vp_adv, enc_fx, err, diff;
  logic signed [GAIN_W:0]    kp_s, kd_s;
  logic signed [PROD_W-1:0]  prod_p, prod_d;
  logic signed [TERM_W-1:0]  term_p, term_d;
  logic signed [DELTA_W-1:0] delta;
  logic signed [NP_W-1:0]    np;
  logic                      np_ok;

  assign spd_sel = (wheel_r == 1'b0) ? spd0_r : spd1_r;
  assign spd_ext = POS_W'(spd_sel);
  assign spd_al  = (FRACTION_BITS >= SPEED_FRAC) ? (spd_ext <<< SHL) : (spd_ext >>> SHR);
  assign vp_adv  = vp_cur + spd_al;
  assign enc_fx  = POS_W'(enc_r) <<< FRACTION_BITS;
  assign err     = vp_adv - enc_fx;
  assign diff    = err - perr_cur;
  assign kp_s    = signed'({1'b0, kp_r});
  assign kd_s    = signed'({1'b0, kd_r});
  assign prod_p  = PROD_W'(err) * PROD_W'(kp_s);
  assign prod_d  = PROD_W'(diff) * PROD_W'(kd_s);
  // dropping the low bits is a floor shift
  assign term_p  = prod_p[PROD_W-1:GAIN_FRAC];
  assign term_d  = prod_d[PROD_W-1:GAIN_FRAC];
  assign delta   = DELTA_W'(term_p) + DELTA_W'(term_d);
  assign np      = NP_W'(acc_cur) + NP_W'(delta);
  assign np_ok   = (np < LIM) && (np > NEG_LIM);

  // Request handling and next state
  logic signed [POS_W-1:0]   vp_upd, perr_upd;
  logic signed [AW-1:0]      acc_upd;
  logic [1:0]                mode_upd;
  logic signed [COUNT_W-1:0] tgt_upd;
  logic signed [PWR_W-1:0]   drive;
  logic                      reached, clamped;

  always_comb begin
    vp_upd   = vp_cur;
    perr_upd = perr_cur;
    acc_upd  = acc_cur;
    mode_upd = mode_cur;
    tgt_upd  = tgt_cur;
    drive    = '0;
    reached  = 1'b0;
    clamped  = 1'b0;
    case (req_r)
      REQ_RUN, REQ_TARGET: begin
        mode_upd = req_r;
        acc_upd  = AW'(sp_r) <<< FRACTION_BITS;
        if (req_r == REQ_TARGET) begin
          tgt_upd = tgt_cnt_r;
        end
        drive = sp_r;
      end
      REQ_TICK: begin
        vp_upd   = vp_adv;
        perr_upd = err;
        if (mode_cur == MODE_TARGET && enc_r >= tgt_cur) begin
          mode_upd = MODE_OFF;
          reached  = 1'b1;
        end else if (mode_cur inside {MODE_RUN, MODE_TARGET}) begin
          if (np_ok) begin
            acc_upd = AW'(np);
          end else begin
            clamped = 1'b1;
          end
        end
        if (mode_upd inside {MODE_RUN, MODE_TARGET}) begin
          drive = trunc_pwr(acc_upd);
        end
      end
      default: begin
        // unused request: report current drive only
        if (mode_cur inside {MODE_RUN, MODE_TARGET}) begin
          drive = trunc_pwr(acc_cur);
        end
      end
    endcase
  end

  // State write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        vp_r[i]   <= '0;
        perr_r[i] <= '0;
        acc_r[i]  <= '0;
        mode_r[i] <= MODE_OFF;
        tgt_r[i]  <= '0;
      end
    end else if (fire && in_range) begin
      vp_r[widx]   <= vp_upd;
      perr_r[widx] <= perr_upd;
      acc_r[widx]  <= acc_upd;
      mode_r[widx] <= mode_upd;
      tgt_r[widx]  <= tgt_upd;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_wheel_out      <= wheel_r;
      out_drive_power    <= in_range ? drive    : '0;
      out_mode_now       <= in_range ? mode_upd : MODE_OFF;
      out_target_reached <= in_range && reached;
      out_power_clamped  <= in_range && clamped;
    end
  end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the two-wheel incremental PD speed regulator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wspd_pkg::*;

  localparam int FRAC            = FRACTION_BITS_DEF;
  localparam logic [1:0] REQ_NONE = 2'd3;   // unused request code
  localparam int PHASES          = 4;
  localparam int BEATS_PER_PHASE = 185;
  localparam int NUM_DIR         = 25;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 80;

  typedef struct packed {
    logic [1:0]                 req;
    logic                       wheel;
    logic signed [COUNT_W-1:0]  enc;
    logic signed [PWR_W-1:0]    sp;
    logic signed [COUNT_W-1:0]  tgt;
  } wheel_req_t;

  typedef struct packed {
    logic                       wheel;
    logic signed [PWR_W-1:0]    drive;
    logic [1:0]                 mode;
    logic                       reached;
    logic                       clamped;
  } drive_res_t;

  // directed row: request fields, then an optional hand-written result
  typedef struct packed {
    logic [1:0]                 req;
    logic                       wheel;
    logic signed [COUNT_W-1:0]  enc;
    logic signed [PWR_W-1:0]    sp;
    logic signed [COUNT_W-1:0]  tgt;
    logic                       typed;
    logic signed [PWR_W-1:0]    drv;
    logic [1:0]                 mode;
    logic                       reached;
    logic                       clamped;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_req_type;
  logic in_wheel;
  logic signed [COUNT_W-1:0] in_encoder_count;
  logic signed [PWR_W-1:0] in_start_power;
  logic signed [COUNT_W-1:0] in_target_count;
  logic out_valid;
  logic out_ready;
  logic out_wheel_out;
  logic signed [PWR_W-1:0] out_drive_power;
  logic [1:0] out_mode_now;
  logic out_target_reached;
  logic out_power_clamped;

  wheel_speed_pd_regulator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_wheel           (in_wheel),
    .in_encoder_count   (in_encoder_count),
    .in_start_power     (in_start_power),
    .in_target_count    (in_target_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_wheel_out      (out_wheel_out),
    .out_drive_power    (out_drive_power),
    .out_mode_now       (out_mode_now),
    .out_target_reached (out_target_reached),
    .out_power_clamped  (out_power_clamped)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the gain and speed registers
  logic [GAIN_W-1:0]         gain_p, gain_d;
  logic signed [SPEED_W-1:0] speed_set [2];

  // Per-wheel regulator state, fixed point with FRAC fraction bits
  longint      vpos     [2];
  longint      last_err [2];
  longint      acc_pwr  [2];
  logic [1:0]  run_st   [2];
  logic signed [COUNT_W-1:0] stop_cnt [2];

  drive_res_t expected_drive [$];

  int idle_pct, stall_pct, rx_hold;
  int err_cnt, n_beats, n_rand, n_results, n_clamped, n_reached;
  int cycle_cnt;

  // Directed requests; rows marked typed carry an obvious result
  dir_row_t dir_rows [NUM_DIR] = '{
    '{REQ_TICK,   1'b0, 32'sd0,        8'sd0,    32'sd0,        1'b1, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_NONE,   1'b1, 32'h7FFFFFFF,  8'sd5,    32'sd0,        1'b1, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_RUN,    1'b0, 32'sd0,        8'sd10,   32'sd0,        1'b1, 8'sd10,   MODE_RUN,    1'b0, 1'b0},
    '{REQ_TICK,   1'b0, 32'sd0,        8'sd0,    32'sd0,        1'b0, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_TICK,   1'b0, 32'h80000000,  8'sd0,    32'sd0,        1'b0, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_TICK,   1'b0, 32'h7FFFFFFF,  8'sd0,    32'sd0,        1'b0, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_TARGET, 1'b1, 32'sd0,        -8'sd100, 32'sd50,       1'b1, -8'sd100, MODE_TARGET, 1'b0, 1'b0},
    '{REQ_TICK,   1'b1, 32'sd0,        8'sd0,    32'sd0,        1'b0, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_TICK,   1'b1, 32'sd50,       8'sd0,    32'sd0,        1'b1, 8'sd0,    MODE_OFF,    1'b1, 1'b0},
    '{REQ_TARGET, 1'b1, 32'sd0,        8'sd127,  32'h7FFFFFFF,  1'b1, 8'sd127,  MODE_TARGET, 1'b0, 1'b0},
    '{REQ_TICK,   1'b1, 32'h7FFFFFFF,  8'sd0,    32'sd0,        1'b1, 8'sd0,    MODE_OFF,    1'b1, 1'b0},
    '{REQ_RUN,    1'b0, 32'sd0,        -8'sd128, 32'sd0,        1'b1, -8'sd128, MODE_RUN,    1'b0, 1'b0},
    '{REQ_TICK,   1'b0, 32'sd0,        8'sd0,    32'sd0,        1'b0, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_TARGET, 1'b0, 32'sd0,        8'sd0,    32'h80000000,  1'b1, 8'sd0,    MODE_TARGET, 1'b0, 1'b0},
    '{REQ_TICK,   1'b0, 32'h80000000,  8'sd0,    32'sd0,        1'b1, 8'sd0,    MODE_OFF,    1'b1, 1'b0},
    '{REQ_RUN,    1'b1, 32'sd0,        8'sd99,   32'sd1234,     1'b1, 8'sd99,   MODE_RUN,    1'b0, 1'b0},
    '{REQ_NONE,   1'b1, 32'sd0,        8'sd0,    32'sd0,        1'b1, 8'sd99,   MODE_RUN,    1'b0, 1'b0},
    '{REQ_TICK,   1'b1, 32'sd3,        8'sd0,    32'sd0,        1'b0, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_TICK,   1'b1, -32'sd3,       8'sd0,    32'sd0,        1'b0, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_TARGET, 1'b1, 32'sd0,        -8'sd99,  -32'sd1000,    1'b1, -8'sd99,  MODE_TARGET, 1'b0, 1'b0},
    '{REQ_TICK,   1'b1, -32'sd1000,    8'sd0,    32'sd0,        1'b1, 8'sd0,    MODE_OFF,    1'b1, 1'b0},
    '{REQ_NONE,   1'b0, 32'sd0,        8'sd5,    32'sd0,        1'b0, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_RUN,    1'b0, 32'sd0,        8'sd100,  32'sd0,        1'b1, 8'sd100,  MODE_RUN,    1'b0, 1'b0},
    '{REQ_TICK,   1'b0, 32'sd0,        8'sd0,    32'sd0,        1'b0, 8'sd0,    MODE_OFF,    1'b0, 1'b0},
    '{REQ_TICK,   1'b1, 32'sd5,        8'sd0,    32'sd0,        1'b1, 8'sd0,    MODE_OFF,    1'b0, 1'b0}
  };

  // Regulator step: update one wheel's state and return its drive result
  function automatic drive_res_t pd_step(input wheel_req_t b);
    drive_res_t r;
    logic w;
    logic signed [POS_W-1:0] w48;
    longint step, err, diff, delta, np, lim;
    w = b.wheel;
    r = '0;
    r.wheel = w;
    lim = longint'(POWER_LIMIT) <<< FRAC;
    if (b.req == REQ_RUN || b.req == REQ_TARGET) begin
      run_st[w]  = b.req;
      acc_pwr[w] = longint'(b.sp) <<< FRAC;
      if (b.req == REQ_TARGET) stop_cnt[w] = b.tgt;
      r.drive = b.sp;
    end else begin
      if (b.req == REQ_TICK) begin
        // speed aligned to the position fraction width
        if (FRAC >= SPEED_FRAC) step = longint'(speed_set[w]) <<< (FRAC - SPEED_FRAC);
        else step = longint'(speed_set[w]) >>> (SPEED_FRAC - FRAC);
        w48 = POS_W'(vpos[w] + step);
        vpos[w] = w48;
        w48 = POS_W'(vpos[w] - (longint'(b.enc) <<< FRAC));
        err = w48;
        w48 = POS_W'(err - last_err[w]);
        diff = w48;
        last_err[w] = err;
        delta = ((err * longint'(gain_p)) >>> GAIN_FRAC)
              + ((diff * longint'(gain_d)) >>> GAIN_FRAC);
        np = acc_pwr[w] + delta;
        if (run_st[w] == MODE_TARGET && b.enc >= stop_cnt[w]) begin
          run_st[w] = MODE_OFF;
          r.reached = 1'b1;
        end else if (run_st[w] != MODE_OFF) begin
          if (np < lim && np > -lim) acc_pwr[w] = np;
          else r.clamped = 1'b1;
        end
      end
      // drive is the power truncated toward zero while running
      if (run_st[w] != MODE_OFF) begin
        if (acc_pwr[w] >= 0) r.drive = PWR_W'(acc_pwr[w] >>> FRAC);
        else r.drive = PWR_W'(-((-acc_pwr[w]) >>> FRAC));
      end
    end
    r.mode = run_st[w];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // Write all four registers while the block is idle
  task automatic load_gains(input logic [15:0] kp, input logic [15:0] kd,
                            input logic [15:0] s0, input logic [15:0] s1);
    logic [15:0] vals [4];
    vals = '{kp, kd, s0, s1};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      case (CFG_IDX_W'(i))
        CFG_KP:     gain_p = vals[i];
        CFG_KD:     gain_d = vals[i];
        CFG_SPEED0: speed_set[0] = vals[i];
        CFG_SPEED1: speed_set[1] = vals[i];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one request beat, hold it until taken, then predict its result
  task automatic send_beat(input wheel_req_t b, input logic typed, input drive_res_t tres);
    drive_res_t r;
    @(negedge clk);
    in_valid         <= 1'b1;
    in_req_type      <= b.req;
    in_wheel         <= b.wheel;
    in_encoder_count <= b.enc;
    in_start_power   <= b.sp;
    in_target_count  <= b.tgt;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = pd_step(b);
    if (typed) r = tres;
    expected_drive.push_back(r);
    n_beats++;
  endtask

  task automatic drain_results();
    while (expected_drive.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    drive_res_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_drive.size() == 0) begin
        flag_mismatch("result beat with nothing pending, drive", out_drive_power, 0);
      end else begin
        want = expected_drive.pop_front();
        if (out_wheel_out !== want.wheel)
          flag_mismatch("wheel_out", out_wheel_out, want.wheel);
        if (out_drive_power !== want.drive)
          flag_mismatch("drive_power", out_drive_power, want.drive);
        if (out_mode_now !== want.mode)
          flag_mismatch("mode_now", out_mode_now, want.mode);
        if (out_target_reached !== want.reached)
          flag_mismatch("target_reached", out_target_reached, want.reached);
        if (out_power_clamped !== want.clamped)
          flag_mismatch("power_clamped", out_power_clamped, want.clamped);
        if (want.clamped) n_clamped++;
        if (want.reached) n_reached++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: timeout after %0d cycles, %0d results pending",
               cycle_cnt, expected_drive.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    wheel_req_t b;
    drive_res_t tres;
    logic w;
    int k, active;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = REQ_TICK;
    in_wheel = 1'b0;
    in_encoder_count = '0;
    in_start_power = '0;
    in_target_count = '0;
    out_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    rx_hold = 0;
    err_cnt = 0;
    n_beats = 0;
    n_rand = 0;
    n_results = 0;
    n_clamped = 0;
    n_reached = 0;
    cycle_cnt = 0;
    gain_p = '0;
    gain_d = '0;
    for (int i = 0; i < 2; i++) begin
      speed_set[i] = '0;
      vpos[i] = 0;
      last_err[i] = 0;
      acc_pwr[i] = 0;
      run_st[i] = MODE_OFF;
      stop_cnt[i] = '0;
    end

    // reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: gain 1.0 / 0.5, speeds +1 and -1 count per tick
    load_gains(16'h1000, 16'h0800, 16'h0100, 16'hFF00);
    for (k = 0; k < NUM_DIR; k++) begin
      b    = '{dir_rows[k].req, dir_rows[k].wheel, dir_rows[k].enc,
               dir_rows[k].sp, dir_rows[k].tgt};
      tres = '{dir_rows[k].wheel, dir_rows[k].drv, dir_rows[k].mode,
               dir_rows[k].reached, dir_rows[k].clamped};
      send_beat(b, dir_rows[k].typed, tres);
    end

    // random part, one gain/speed setting and idling profile per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      @(negedge clk);
      in_valid <= 1'b0;
      drain_results();
      case (ph)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          load_gains(16'h0400, 16'h0200, 16'h0180, 16'hFF00);
        end
        1: begin
          idle_pct = 49; stall_pct = 0;
          load_gains(16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
        end
        2: begin
          idle_pct = 0;  stall_pct = 49;
          load_gains(16'hFFFF, 16'hFFFF, 16'($urandom), 16'($urandom));
        end
        default: begin
          idle_pct = 13; stall_pct = 13;
          load_gains(16'($urandom_range(16'h3000)), 16'($urandom_range(16'h3000)),
                     16'($urandom), 16'($urandom));
        end
      endcase

      active = 0;
      k = 0;
      while (active < BEATS_PER_PHASE) begin
        // long output hold-off while requests keep coming
        if (ph == 2 && k == 40) rx_hold = HOLD_CYCLES;
        // pause the request side until every result is back
        if (ph == 1 && k == 100) begin
          @(negedge clk);
          in_valid <= 1'b0;
          drain_results();
        end
        while ($urandom_range(99) < idle_pct) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end

        w = 1'($urandom_range(1));
        b.wheel = w;
        b.enc = $urandom;
        b.sp  = 8'($urandom);
        b.tgt = $urandom;
        if ($urandom_range(99) < 80) begin
          // well-formed: starts now and then, ticks tracking the set point
          if ($urandom_range(99) < 12 || (run_st[w] == MODE_OFF && $urandom_range(1) == 1)) begin
            b.req = $urandom_range(1) ? REQ_RUN : REQ_TARGET;
            b.sp  = 8'(int'($urandom_range(180)) - 90);
            b.tgt = 32'(int'(vpos[w] >>> FRAC) + int'($urandom_range(60)));
          end else begin
            b.req = REQ_TICK;
            b.enc = 32'(int'(vpos[w] >>> FRAC) + int'($urandom_range(6)) - 3);
          end
        end else begin
          b.req = 2'($urandom_range(3));
        end
        send_beat(b, 1'b0, '0);
        if (b.req != REQ_NONE) active++;
        n_rand++;
        k++;
      end
    end

    // wind down
    @(negedge clk);
    in_valid <= 1'b0;
    drain_results();
    repeat (4) @(posedge clk);

    $display("testbench: %0d request beats (%0d random) over %0d gain/speed settings, %0d results",
             n_beats, n_rand, PHASES + 1, n_results);
    $display("testbench: %0d clamped updates, %0d target stops, long output stall and drain seen",
             n_clamped, n_reached);
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
